// File: rtl/fwd_pkg.sv
// ----------------------------------------------------------------------------
// fwd_pkg
// Shared constants, register and input codes, and sequencer states of the
// fractional window decimator.
// ----------------------------------------------------------------------------
package fwd_pkg;

  localparam int DEF_BUFFER_DEPTH = 256;
  localparam int DEF_SAMPLE_BITS  = 24;

  localparam int BIN_W      = 24;
  localparam int DIST_W     = 26;
  localparam int CNT_W      = 10;
  localparam int LEFT_W     = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [BIN_W-1:0] ONE_Q16 = BIN_W'(65536);

  localparam logic [CFG_IDX_W-1:0] REG_BIN_SIZE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MODE     = CFG_IDX_W'(1);

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_FLUSH  = 1'b1;

  localparam logic MODE_MEAN = 1'b0;
  localparam logic MODE_PEAK = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_SCAN,
    ST_EMIT
  } state_t;

endpackage

// File: rtl/fractional_window_decimator.sv
// ----------------------------------------------------------------------------
// fractional_window_decimator
// Boxcar decimator with a Q8.16 window length, mean or peak-deviation output.
// ----------------------------------------------------------------------------
// Samples that close no window stream back to back. A beat that closes a
// window, or a flush with leftover samples, holds the input stalled while the
// divider or the peak scan works. In mean mode the iterative divider forms the
// quotient, which passes through the result register to the output register.
// In peak mode the buffer scan reads one stored sample per cycle through a
// multiply and compare pipeline. The input is taken even while a finished
// result still waits at the output, and is stalled while a register write is
// offered.
// ----------------------------------------------------------------------------
module fractional_window_decimator #(
  parameter int BUFFER_DEPTH = fwd_pkg::DEF_BUFFER_DEPTH,
  parameter int SAMPLE_BITS  = fwd_pkg::DEF_SAMPLE_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               kind,
  input  logic signed [SAMPLE_BITS-1:0]      sample,
  input  logic                               sample_valid,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [SAMPLE_BITS-1:0]      value,
  output logic                               empty_res,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [fwd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fwd_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int CNT_W  = fwd_pkg::CNT_W;
  localparam int LEFT_W = fwd_pkg::LEFT_W;
  localparam int DIST_W = fwd_pkg::DIST_W;
  localparam int BIN_W  = fwd_pkg::BIN_W;
  localparam int SUM_W  = SAMPLE_BITS + CNT_W;
  localparam int ADDR_W = $clog2(BUFFER_DEPTH);

  fwd_pkg::state_t state, state_next;

  logic [BIN_W-1:0]         bin_size;
  logic                     mode;
  logic signed [DIST_W-1:0] edge_distance;
  logic signed [SUM_W-1:0]  window_sum;
  logic [CNT_W-1:0]         valid_count;
  logic [LEFT_W-1:0]        leftover_count;
  logic signed [SUM_W-1:0]  previous_sum;
  logic [CNT_W-1:0]         previous_count;

  logic signed [SAMPLE_BITS-1:0] res_value;
  logic                          res_empty;

  logic                     acc;
  logic                     cfg_acc;
  logic                     out_free;
  logic signed [SUM_W-1:0]  s_ext;
  logic signed [SUM_W-1:0]  sum_upd;
  logic [CNT_W-1:0]         cnt_upd;
  logic                     is_edge;
  logic                     launch;
  logic signed [SUM_W-1:0]  launch_sum;
  logic [CNT_W-1:0]         launch_cnt;
  logic signed [DIST_W-1:0] eff_bin;
  logic signed [DIST_W-1:0] eff_cfg;
  logic signed [DIST_W-1:0] one_q16;

  logic div_start, div_done;
  logic scan_start, scan_done;
  logic load_out;
  logic signed [SAMPLE_BITS-1:0] div_quotient;
  logic signed [SAMPLE_BITS-1:0] scan_best;
  logic                          wr_en;
  logic [ADDR_W-1:0]             wr_addr;

  assign acc      = in_valid && !in_stall;
  assign cfg_acc  = cfg_valid && cfg_ready;
  assign cfg_ready = 1'b1;
  assign in_stall = (state != fwd_pkg::ST_IDLE) || cfg_valid;
  assign out_free = !out_valid || !out_stall;
  assign one_q16  = $signed(DIST_W'(fwd_pkg::ONE_Q16));

  assign eff_bin = (bin_size < fwd_pkg::ONE_Q16) ? one_q16 : $signed(DIST_W'(bin_size));
  assign eff_cfg = (cfg_data[BIN_W-1:0] < fwd_pkg::ONE_Q16) ? one_q16
                 : $signed(DIST_W'(cfg_data[BIN_W-1:0]));

  assign s_ext   = SUM_W'(sample);
  assign sum_upd = sample_valid ? (window_sum + s_ext) : window_sum;
  assign cnt_upd = valid_count + CNT_W'(sample_valid);
  assign is_edge = edge_distance <= $signed(DIST_W'(0));

  always_comb begin
    if (kind == fwd_pkg::KIND_FLUSH) begin
      launch = leftover_count != '0;
      if (mode == fwd_pkg::MODE_PEAK) begin
        launch_sum = window_sum;
        launch_cnt = valid_count;
      end else begin
        launch_sum = window_sum + previous_sum;
        launch_cnt = valid_count + previous_count;
      end
    end else begin
      launch     = is_edge;
      launch_sum = sum_upd;
      launch_cnt = cnt_upd;
    end
  end

  assign wr_en   = acc && (kind == fwd_pkg::KIND_SAMPLE) && sample_valid
                && (32'(valid_count) < BUFFER_DEPTH);
  assign wr_addr = ADDR_W'(valid_count);

  always_comb begin
    state_next = state;
    unique case (state)
      fwd_pkg::ST_IDLE: begin
        if (acc && launch) begin
          priority if (launch_cnt == '0) begin
            state_next = fwd_pkg::ST_EMIT;
          end else if (mode == fwd_pkg::MODE_PEAK) begin
            state_next = fwd_pkg::ST_SCAN;
          end else begin
            state_next = fwd_pkg::ST_DIV;
          end
        end
      end
      fwd_pkg::ST_DIV: begin
        if (div_done) begin
          state_next = fwd_pkg::ST_EMIT;
        end
      end
      fwd_pkg::ST_SCAN: begin
        if (scan_done) begin
          state_next = fwd_pkg::ST_EMIT;
        end
      end
      fwd_pkg::ST_EMIT: begin
        if (out_free) begin
          state_next = fwd_pkg::ST_IDLE;
        end
      end
      default: state_next = fwd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    div_start  = 1'b0;
    scan_start = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      fwd_pkg::ST_IDLE: begin
        if (acc && launch && (launch_cnt != '0)) begin
          div_start  = mode == fwd_pkg::MODE_MEAN;
          scan_start = mode == fwd_pkg::MODE_PEAK;
        end
      end
      fwd_pkg::ST_EMIT: load_out = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fwd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_size       <= fwd_pkg::ONE_Q16;
      mode           <= fwd_pkg::MODE_MEAN;
      edge_distance  <= '0;
      window_sum     <= '0;
      valid_count    <= '0;
      leftover_count <= '0;
      previous_sum   <= '0;
      previous_count <= '0;
    end else if (cfg_acc) begin
      if (cfg_index == fwd_pkg::REG_BIN_SIZE) begin
        bin_size      <= cfg_data[BIN_W-1:0];
        edge_distance <= eff_cfg - one_q16;
      end else if (cfg_index == fwd_pkg::REG_MODE) begin
        mode <= cfg_data[0];
      end
    end else if (acc) begin
      if (kind == fwd_pkg::KIND_FLUSH) begin
        edge_distance  <= eff_bin - one_q16;
        window_sum     <= '0;
        valid_count    <= '0;
        leftover_count <= '0;
        previous_sum   <= '0;
        previous_count <= '0;
      end else if (is_edge) begin
        edge_distance  <= edge_distance + eff_bin - one_q16;
        previous_sum   <= sum_upd;
        previous_count <= cnt_upd;
        window_sum     <= '0;
        valid_count    <= '0;
        leftover_count <= '0;
      end else begin
        edge_distance  <= edge_distance - one_q16;
        window_sum     <= sum_upd;
        valid_count    <= cnt_upd;
        leftover_count <= leftover_count + LEFT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state == fwd_pkg::ST_IDLE) && acc && launch && (launch_cnt == '0)) begin
      res_value <= '0;
      res_empty <= 1'b1;
    end else if ((state == fwd_pkg::ST_DIV) && div_done) begin
      res_value <= div_quotient;
      res_empty <= 1'b0;
    end else if ((state == fwd_pkg::ST_SCAN) && scan_done) begin
      res_value <= scan_best;
      res_empty <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      value     <= res_value;
      empty_res <= res_empty;
    end
  end

  fwd_div #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (launch_sum),
    .divisor  (launch_cnt),
    .done     (div_done),
    .quotient (div_quotient)
  );

  fwd_peak #(
    .BUFFER_DEPTH (BUFFER_DEPTH),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_peak (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (sample),
    .start   (scan_start),
    .sum     (launch_sum),
    .cnt     (launch_cnt),
    .done    (scan_done),
    .best    (scan_best)
  );

  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == fwd_pkg::ST_DIV)
    else $error("divider finished outside its state");

  a_scan_done_in_scan: assert property (@(posedge clk) disable iff (rst)
    scan_done |-> state == fwd_pkg::ST_SCAN)
    else $error("peak scan finished outside its state");

  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    (acc && (kind == fwd_pkg::KIND_FLUSH)) |=>
      (valid_count == '0) && (leftover_count == '0) && (previous_count == '0))
    else $error("flush left window counts behind");

  a_count_order: assert property (@(posedge clk) disable iff (rst)
    valid_count <= CNT_W'(leftover_count))
    else $error("valid count exceeds samples since last edge");

endmodule

// File: rtl/fwd_div.sv
// ----------------------------------------------------------------------------
// fwd_div
// Iterative restoring divider: signed window sum by unsigned count, one
// quotient bit per cycle, truncated toward zero.
// ----------------------------------------------------------------------------
module fwd_div #(
  parameter int SAMPLE_BITS = fwd_pkg::DEF_SAMPLE_BITS
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          start,
  input  logic signed [SAMPLE_BITS+fwd_pkg::CNT_W-1:0]  dividend,
  input  logic        [fwd_pkg::CNT_W-1:0]              divisor,
  output logic                                          done,
  output logic signed [SAMPLE_BITS-1:0]                 quotient
);

  localparam int SUM_W  = SAMPLE_BITS + fwd_pkg::CNT_W;
  localparam int CNT_W  = fwd_pkg::CNT_W;
  localparam int STEP_W = $clog2(SUM_W + 1);

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [CNT_W:0]    rem;
  logic [SUM_W-1:0]  quo;
  logic [CNT_W-1:0]  dvs;
  logic              neg;

  logic [CNT_W:0]    shifted;
  logic              fits;
  logic [SUM_W-1:0]  quo_signed;

  assign shifted    = {rem[CNT_W-1:0], quo[SUM_W-1]};
  assign fits       = shifted >= {1'b0, dvs};
  assign quo_signed = neg ? (~quo + SUM_W'(1)) : quo;
  assign quotient   = $signed(quo_signed[SAMPLE_BITS-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= STEP_W'(SUM_W);
      end else if (busy) begin
        step <= step - STEP_W'(1);
        if (step == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[SUM_W-1];
      quo <= dividend[SUM_W-1] ? (~dividend + SUM_W'(1)) : dividend;
      dvs <= divisor;
      rem <= '0;
    end else if (busy) begin
      rem <= fits ? (shifted - {1'b0, dvs}) : shifted;
      quo <= {quo[SUM_W-2:0], fits};
    end
  end

endmodule

// File: rtl/fwd_peak.sv
// ----------------------------------------------------------------------------
// fwd_peak
// Window sample buffer and peak scan: reads stored samples one per cycle,
// forms |sample * count - sum| and keeps the first largest.
// ----------------------------------------------------------------------------
module fwd_peak #(
  parameter int BUFFER_DEPTH = fwd_pkg::DEF_BUFFER_DEPTH,
  parameter int SAMPLE_BITS  = fwd_pkg::DEF_SAMPLE_BITS
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          wr_en,
  input  logic        [$clog2(BUFFER_DEPTH)-1:0]        wr_addr,
  input  logic signed [SAMPLE_BITS-1:0]                 wr_data,
  input  logic                                          start,
  input  logic signed [SAMPLE_BITS+fwd_pkg::CNT_W-1:0]  sum,
  input  logic        [fwd_pkg::CNT_W-1:0]              cnt,
  output logic                                          done,
  output logic signed [SAMPLE_BITS-1:0]                 best
);

  localparam int ADDR_W = $clog2(BUFFER_DEPTH);
  localparam int IDX_W  = ADDR_W + 1;
  localparam int CNT_W  = fwd_pkg::CNT_W;
  localparam int SUM_W  = SAMPLE_BITS + CNT_W;
  localparam int PROD_W = SUM_W + 1;
  localparam int DEV_W  = SUM_W + 2;

  logic signed [SAMPLE_BITS-1:0] mem [BUFFER_DEPTH];

  logic                     run;
  logic [IDX_W-1:0]         idx;
  logic [IDX_W-1:0]         stored;
  logic signed [SUM_W-1:0]  sum_l;
  logic [CNT_W-1:0]         cnt_l;

  logic signed [SAMPLE_BITS-1:0] rdata;
  logic                          v1, f1, l1;
  logic signed [PROD_W-1:0]      prod;
  logic signed [SAMPLE_BITS-1:0] samp2;
  logic                          v2, f2, l2;
  logic [DEV_W-1:0]              best_dev;

  logic                    last_issue;
  logic signed [DEV_W-1:0] diff;
  logic [DEV_W-1:0]        dev;
  logic [IDX_W-1:0]        stored_next;

  assign last_issue  = idx == (stored - IDX_W'(1));
  assign diff        = DEV_W'(prod) - DEV_W'(sum_l);
  assign dev         = diff[DEV_W-1] ? DEV_W'(-diff) : DEV_W'(diff);
  assign stored_next = (32'(cnt) < BUFFER_DEPTH) ? IDX_W'(cnt) : IDX_W'(BUFFER_DEPTH);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata <= mem[idx[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      v1   <= 1'b0;
      v2   <= 1'b0;
      l1   <= 1'b0;
      l2   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= run;
      l1   <= run && last_issue;
      v2   <= v1;
      l2   <= v1 && l1;
      done <= v2 && l2;
      if (start) begin
        run <= 1'b1;
      end else if (run && last_issue) begin
        run <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      idx    <= '0;
      stored <= stored_next;
      sum_l  <= sum;
      cnt_l  <= cnt;
    end else if (run) begin
      idx <= idx + IDX_W'(1);
    end
    f1    <= idx == '0;
    f2    <= f1;
    prod  <= rdata * $signed({1'b0, cnt_l});
    samp2 <= rdata;
    if (v2 && (f2 || (dev > best_dev))) begin
      best_dev <= dev;
      best     <= samp2;
    end
  end

endmodule

// File: tb/sv/fwd_window_checker.sv
// ----------------------------------------------------------------------------
// fwd_window_checker
// Watches the sample, result and register channels of the fractional window
// decimator, keeps its own model of window position, sums and buffer, and
// compares every result beat in order with the predicted window result.
// ----------------------------------------------------------------------------
module fwd_window_checker #(
  parameter int BUFFER_DEPTH = fwd_pkg::DEF_BUFFER_DEPTH,
  parameter int SAMPLE_BITS  = fwd_pkg::DEF_SAMPLE_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic                           kind,
  input  logic signed [SAMPLE_BITS-1:0]  sample,
  input  logic                           sample_valid,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic signed [SAMPLE_BITS-1:0]  value,
  input  logic                           empty_res,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [fwd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fwd_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             fail_count,
  output int                             pending
);

  localparam int UNIT = fwd_pkg::ONE_Q16;

  typedef struct {
    logic signed [SAMPLE_BITS-1:0] value;
    logic                          empty;
  } window_result_t;

  window_result_t expected_windows[$];

  logic [fwd_pkg::BIN_W-1:0] bin_q16;
  logic             out_mode;
  int               edge_pos;
  longint           win_sum;
  int               win_cnt;
  int               left_cnt;
  longint           prev_sum;
  int               prev_cnt;
  longint           win_samples[BUFFER_DEPTH];

  function automatic int eff_bin();
    return (int'(bin_q16) < UNIT) ? UNIT : int'(bin_q16);
  endfunction

  task automatic restart_stream();
    edge_pos = eff_bin() - UNIT;
    win_sum = 0;
    win_cnt = 0;
    left_cnt = 0;
    prev_sum = 0;
    prev_cnt = 0;
  endtask

  task automatic push_window(input longint sum, input int cnt);
    window_result_t r;
    int             stored;
    int             best;
    longint         best_dev;
    longint         dev;
    r.value = '0;
    r.empty = 1'b1;
    if (cnt != 0) begin
      r.empty = 1'b0;
      if (out_mode == fwd_pkg::MODE_MEAN) begin
        r.value = SAMPLE_BITS'(sum / cnt);
      end else begin
        stored = (cnt < BUFFER_DEPTH) ? cnt : BUFFER_DEPTH;
        best = 0;
        best_dev = 0;
        for (int i = 0; i < stored; i++) begin
          dev = win_samples[i] * cnt - sum;
          if (dev < 0) dev = -dev;
          if (dev > best_dev) begin
            best_dev = dev;
            best = i;
          end
        end
        r.value = SAMPLE_BITS'(win_samples[best]);
      end
    end
    expected_windows.push_back(r);
  endtask

  task automatic apply_write(input logic [fwd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [fwd_pkg::CFG_DATA_W-1:0] data);
    if (idx == fwd_pkg::REG_BIN_SIZE) begin
      bin_q16 = data[fwd_pkg::BIN_W-1:0];
      edge_pos = eff_bin() - UNIT;
    end else if (idx == fwd_pkg::REG_MODE) begin
      out_mode = data[0];
    end
  endtask

  task automatic decimate_beat(input logic k, input logic signed [SAMPLE_BITS-1:0] s,
                               input logic v);
    if (k == fwd_pkg::KIND_FLUSH) begin
      if (left_cnt > 0) begin
        if (out_mode == fwd_pkg::MODE_PEAK) push_window(win_sum, win_cnt);
        else push_window(win_sum + prev_sum, win_cnt + prev_cnt);
      end
      restart_stream();
    end else begin
      if (v) begin
        if (win_cnt < BUFFER_DEPTH) win_samples[win_cnt] = longint'(s);
        win_sum += longint'(s);
        win_cnt++;
      end
      if (edge_pos <= 0) begin
        push_window(win_sum, win_cnt);
        edge_pos += eff_bin();
        prev_sum = win_sum;
        prev_cnt = win_cnt;
        win_sum = 0;
        win_cnt = 0;
        left_cnt = 0;
      end else begin
        left_cnt++;
      end
      edge_pos -= UNIT;
    end
  endtask

  task automatic check_window();
    window_result_t exp_r;
    int             bad;
    bad = 0;
    if (expected_windows.size() == 0) begin
      $error("value: unexpected result beat, actual %0d empty_res %0b", value, empty_res);
      bad = 1;
    end else begin
      exp_r = expected_windows.pop_front();
      if (value !== exp_r.value) begin
        $error("value: expected %0d, actual %0d", exp_r.value, value);
        bad++;
      end
      if (empty_res !== exp_r.empty) begin
        $error("empty_res: expected %0b, actual %0b", exp_r.empty, empty_res);
        bad++;
      end
    end
    fail_count <= fail_count + bad;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      bin_q16 = fwd_pkg::ONE_Q16;
      out_mode = fwd_pkg::MODE_MEAN;
      restart_stream();
      expected_windows.delete();
      fail_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) apply_write(cfg_index, cfg_data);
      if (in_valid && !in_stall) decimate_beat(kind, sample, sample_valid);
      if (out_valid && !out_stall) check_window();
    end
    pending <= expected_windows.size();
  end

endmodule

// File: tb/sv/tb_fractional_window_decimator.sv
// ----------------------------------------------------------------------------
// tb_fractional_window_decimator
// Drives the fractional window decimator with a directed pass over extreme
// samples, empty windows, flushes and saturating window lengths, then with
// random phases of samples and flushes under changing window length and output
// mode, with random gaps on both channels. A checker beside the block predicts
// every window result; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_fractional_window_decimator;

  localparam int SAMPLE_BITS = fwd_pkg::DEF_SAMPLE_BITS;
  localparam int CFG_IDX_W   = fwd_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W  = fwd_pkg::CFG_DATA_W;
  localparam int ITEM_TARGET = 1850;
  localparam int DRAIN       = 320;
  localparam int LIMIT       = 4000;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);

  localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                          in_valid;
  logic                          in_stall;
  logic                          kind;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          sample_valid;
  logic                          out_valid;
  logic                          out_stall;
  logic signed [SAMPLE_BITS-1:0] value;
  logic                          empty_res;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [CFG_IDX_W-1:0]          cfg_index;
  logic [CFG_DATA_W-1:0]         cfg_data;

  int fail_count;
  int pending;
  int items;
  int idle_cycles;
  bit calm;

  always #5 clk = ~clk;

  fractional_window_decimator dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .kind         (kind),
    .sample       (sample),
    .sample_valid (sample_valid),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .value        (value),
    .empty_res    (empty_res),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  fwd_window_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .kind         (kind),
    .sample       (sample),
    .sample_valid (sample_valid),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .value        (value),
    .empty_res    (empty_res),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (calm || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(9))
      0:       return S_MAX;
      1:       return S_MIN;
      2, 3:    return SAMPLE_BITS'(int'($urandom_range(6)) - 3);
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_bin();
    case ($urandom_range(19))
      0:          return CFG_DATA_W'($urandom_range(65535));
      1:          return '1;
      2, 3:       return fwd_pkg::ONE_Q16;
      4:          return CFG_DATA_W'($urandom_range(16 * 65536, 24'hFFFFFF));
      5, 6, 7:    return CFG_DATA_W'($urandom_range(4 * 65536, 16 * 65536));
      default:    return CFG_DATA_W'($urandom_range(65536, 4 * 65536));
    endcase
  endfunction

  task automatic send_beat(input logic k, input logic signed [SAMPLE_BITS-1:0] s,
                           input logic v);
    int unsigned gap;
    in_valid     <= 1'b1;
    kind         <= k;
    sample       <= s;
    sample_valid <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items++;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // hold off until every window result is out and the block has gone quiet
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int unsigned run;
    int unsigned len;
    out_stall <= 1'b0;
    while (rst) @(posedge clk);
    forever begin
      run = 1 + $urandom_range(calm ? 40 : 6);
      out_stall <= 1'b0;
      repeat (run) @(posedge clk);
      len = pick_gap();
      if (len != 0) begin
        out_stall <= 1'b1;
        repeat (len) @(posedge clk);
      end
    end
  end

  initial begin
    int unsigned burst;
    in_valid     <= 1'b0;
    kind         <= fwd_pkg::KIND_SAMPLE;
    sample       <= '0;
    sample_valid <= 1'b0;
    cfg_valid    <= 1'b0;
    cfg_index    <= fwd_pkg::REG_BIN_SIZE;
    cfg_data     <= '0;
    items = 0;
    calm = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_reg(fwd_pkg::REG_BIN_SIZE, fwd_pkg::ONE_Q16);
    write_reg(fwd_pkg::REG_MODE, CFG_DATA_W'(fwd_pkg::MODE_MEAN));
    cfg_valid <= 1'b0;
    send_beat(fwd_pkg::KIND_SAMPLE, S_MAX, 1'b1);
    send_beat(fwd_pkg::KIND_SAMPLE, S_MIN, 1'b1);
    send_beat(fwd_pkg::KIND_SAMPLE, 24'sd77, 1'b0);

    // fractional window, then flushes with no leftover samples to merge
    settle();
    write_reg(fwd_pkg::REG_BIN_SIZE, 24'd163840);
    write_reg(REG_SPARE_A, '1);
    cfg_valid <= 1'b0;
    send_beat(fwd_pkg::KIND_SAMPLE, 24'sd5, 1'b1);
    send_beat(fwd_pkg::KIND_SAMPLE, 24'sd7, 1'b1);
    send_beat(fwd_pkg::KIND_SAMPLE, -24'sd3, 1'b1);
    send_beat(fwd_pkg::KIND_SAMPLE, 24'sd9, 1'b0);
    send_beat(fwd_pkg::KIND_SAMPLE, 24'sd100, 1'b1);
    send_beat(fwd_pkg::KIND_FLUSH, S_MAX, 1'b1);
    send_beat(fwd_pkg::KIND_FLUSH, S_MIN, 1'b0);

    settle();
    write_reg(fwd_pkg::REG_MODE, CFG_DATA_W'(fwd_pkg::MODE_PEAK));
    write_reg(fwd_pkg::REG_BIN_SIZE, 24'd196608);
    cfg_valid <= 1'b0;
    send_beat(fwd_pkg::KIND_SAMPLE, 24'sd1, 1'b1);
    send_beat(fwd_pkg::KIND_SAMPLE, 24'sd10, 1'b1);
    send_beat(fwd_pkg::KIND_SAMPLE, -24'sd20, 1'b1);
    send_beat(fwd_pkg::KIND_SAMPLE, 24'sd4, 1'b1);
    send_beat(fwd_pkg::KIND_FLUSH, '0, 1'b1);

    // window lengths below one sample saturate
    settle();
    write_reg(fwd_pkg::REG_BIN_SIZE, '0);
    cfg_valid <= 1'b0;
    send_beat(fwd_pkg::KIND_SAMPLE, 24'sd3, 1'b1);
    send_beat(fwd_pkg::KIND_SAMPLE, -24'sd3, 1'b1);
    settle();
    write_reg(fwd_pkg::REG_BIN_SIZE, 24'h00FFFF);
    write_reg(fwd_pkg::REG_MODE, CFG_DATA_W'(fwd_pkg::MODE_MEAN));
    cfg_valid <= 1'b0;
    send_beat(fwd_pkg::KIND_SAMPLE, 24'sd2, 1'b1);

    // reload length and switch mode in mid-stream
    settle();
    write_reg(fwd_pkg::REG_BIN_SIZE, 24'd262144);
    cfg_valid <= 1'b0;
    send_beat(fwd_pkg::KIND_SAMPLE, 24'sd6, 1'b1);
    settle();
    write_reg(fwd_pkg::REG_MODE, CFG_DATA_W'(fwd_pkg::MODE_PEAK));
    cfg_valid <= 1'b0;
    send_beat(fwd_pkg::KIND_SAMPLE, S_MAX, 1'b1);
    send_beat(fwd_pkg::KIND_SAMPLE, S_MIN, 1'b1);
    send_beat(fwd_pkg::KIND_SAMPLE, '0, 1'b1);
    send_beat(fwd_pkg::KIND_FLUSH, '0, 1'b0);

    settle();
    write_reg(fwd_pkg::REG_BIN_SIZE, '1);
    write_reg(fwd_pkg::REG_MODE, CFG_DATA_W'(fwd_pkg::MODE_MEAN));
    cfg_valid <= 1'b0;
    send_beat(fwd_pkg::KIND_SAMPLE, S_MAX, 1'b1);
    send_beat(fwd_pkg::KIND_SAMPLE, S_MAX, 1'b1);
    send_beat(fwd_pkg::KIND_SAMPLE, S_MIN, 1'b0);
    send_beat(fwd_pkg::KIND_FLUSH, '0, 1'b1);

    items = 0;
    while (items < ITEM_TARGET) begin
      calm = ($urandom_range(3) == 0);
      settle();
      if ($urandom_range(4) != 0) write_reg(fwd_pkg::REG_BIN_SIZE, pick_bin());
      write_reg(fwd_pkg::REG_MODE, {(CFG_DATA_W-1)'($urandom), 1'($urandom_range(1))});
      if ($urandom_range(7) == 0)
        write_reg($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B,
                  CFG_DATA_W'($urandom));
      cfg_valid <= 1'b0;
      burst = $urandom_range(40, 200);
      repeat (burst) begin
        if ($urandom_range(31) == 0)
          send_beat(fwd_pkg::KIND_FLUSH, pick_sample(), 1'($urandom_range(1)));
        else
          send_beat(fwd_pkg::KIND_SAMPLE, pick_sample(), $urandom_range(99) < 85);
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
